>>> rtl/arf_rate_step_controller_macros.svh
// Assertion helpers for the rate step controller
`ifndef ARF_RATE_STEP_CONTROLLER_MACROS_SVH
`define ARF_RATE_STEP_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ARF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ARF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/arf_pkg.sv
package arf_pkg;

	typedef logic [7:0] cnt_t;

	typedef struct packed {
		logic acked;
		logic first_only;
		logic min_rate_frame;
	} in_t;

	typedef struct packed {
		logic [3:0] rate_index;
		logic       stepped_up;
		logic       stepped_down;
	} out_t;

	typedef struct packed {
		logic [4:0] rate_total;
		logic [3:0] lowest_index;
		cnt_t       fail_limit;
		cnt_t       success_limit;
	} cfg_t;

	typedef struct packed {
		logic up;
		logic down;
	} step_flags_t;

	typedef enum logic [1:0] {
		REG_RATE_TOTAL    = 2'd0,
		REG_LOWEST_INDEX  = 2'd1,
		REG_FAIL_LIMIT    = 2'd2,
		REG_SUCCESS_LIMIT = 2'd3
	} reg_idx_t;

	localparam cfg_t CFG_RESET = '{
		rate_total:    5'd12,
		lowest_index:  4'd0,
		fail_limit:    8'd2,
		success_limit: 8'd10
	};

	function automatic cnt_t sat_inc(input cnt_t v);
		return (v == 8'hFF) ? v : cnt_t'(v + 8'd1);
	endfunction

endpackage

>>> rtl/arf_rate_step_controller.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | in_data  (acked, first_only, min_rate_frame)
// out     | output    | out_valid/out_ready| out_data (rate_index, stepped_up, stepped_down)
// cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// One report per cycle unless the result stalls: input register, one pass of counter
// update logic, result register. A report goes from the input register to the result
// register; the counter read-modify-write of the current rate's slot is the rate-setting loop.
// Reset clears the rate, all counters and loads the register defaults at once.
// A stalled result holds the input stage; min-rate reports are dropped without a result.
module arf_rate_step_controller #(
	parameter int RATE_SLOTS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  arf_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output arf_pkg::out_t  out_data,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [7:0]     cfg_data
);
	import arf_pkg::*;

	`include "arf_rate_step_controller_macros.svh"

	localparam int IW = $clog2(RATE_SLOTS);

	cfg_t          cfg_q;
	logic [IW-1:0] rate_q;
	cnt_t          succ_q [RATE_SLOTS];
	cnt_t          fail_q [RATE_SLOTS];

	logic          valid_s1;
	in_t           item_s1;
	logic          adv_s1;
	logic          upd_s1;

	logic          out_valid_q;
	out_t          out_q;

	logic [IW-1:0] nxt_rate;
	cnt_t          succ_nxt;
	cnt_t          fail_nxt;
	cnt_t          preset;
	step_flags_t   flags;
	logic [3:0]    rate_index;
	logic [IW-1:0] rate_up;

	// Dropped reports need no room in the result register
	assign adv_s1   = valid_s1 && (item_s1.min_rate_frame || !out_valid_q || out_ready);
	assign upd_s1   = adv_s1 && !item_s1.min_rate_frame;
	assign in_ready = !valid_s1 || adv_s1;
	assign rate_up  = IW'(rate_q + IW'(1));

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	arf_step #(
		.RATE_SLOTS(RATE_SLOTS)
	) u_step (
		.cur       (rate_q),
		.succ_cnt  (succ_q[rate_q]),
		.fail_cnt  (fail_q[rate_q]),
		.cfg       (cfg_q),
		.item      (item_s1),
		.nxt_rate  (nxt_rate),
		.succ_nxt  (succ_nxt),
		.fail_nxt  (fail_nxt),
		.preset    (preset),
		.flags     (flags),
		.rate_index(rate_index)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RATE_TOTAL:    cfg_q.rate_total    <= cfg_data[4:0];
				REG_LOWEST_INDEX:  cfg_q.lowest_index  <= cfg_data[3:0];
				REG_FAIL_LIMIT:    cfg_q.fail_limit    <= cfg_data;
				REG_SUCCESS_LIMIT: cfg_q.success_limit <= cfg_data;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= '0;
			for (int i = 0; i < RATE_SLOTS; i++) begin
				succ_q[i] <= '0;
				fail_q[i] <= '0;
			end
		end else if (upd_s1) begin
			rate_q         <= nxt_rate;
			succ_q[rate_q] <= succ_nxt;
			fail_q[rate_q] <= fail_nxt;
			// preset the failures of the rate stepped up to
			if (flags.up) begin
				fail_q[rate_up] <= preset;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_s1) begin
			out_q.rate_index   <= rate_index;
			out_q.stepped_up   <= flags.up;
			out_q.stepped_down <= flags.down;
		end
	end

	`ARF_ASSERT_IMP(a_one_step_dir, clk, arst_n, out_valid_q, !(out_q.stepped_up && out_q.stepped_down), "both ways")
	`ARF_ASSERT_NEXT(a_step_up_moves, clk, arst_n, upd_s1 && flags.up, rate_q == IW'($past(rate_q) + IW'(1)), "no step")
	`ARF_ASSERT_IMP(a_ready_when_free, clk, arst_n, !out_valid_q, in_ready, "input stalled when empty")

endmodule

>>> rtl/arf_step.sv
module arf_step #(
	parameter int RATE_SLOTS = 16
) (
	input  logic [$clog2(RATE_SLOTS)-1:0] cur,
	input  arf_pkg::cnt_t                 succ_cnt,
	input  arf_pkg::cnt_t                 fail_cnt,
	input  arf_pkg::cfg_t                 cfg,
	input  arf_pkg::in_t                  item,
	output logic [$clog2(RATE_SLOTS)-1:0] nxt_rate,
	output arf_pkg::cnt_t                 succ_nxt,
	output arf_pkg::cnt_t                 fail_nxt,
	output arf_pkg::cnt_t                 preset,
	output arf_pkg::step_flags_t          flags,
	output logic [3:0]                    rate_index
);
	import arf_pkg::*;

	localparam int IW = $clog2(RATE_SLOTS);
	localparam int CW = ((IW + 1) > 5) ? (IW + 1) : 5;

	logic [CW-1:0] cur_ext;
	logic [CW-1:0] cur_plus;
	logic [CW-1:0] nxt_ext;
	cnt_t          succ_a;
	cnt_t          fail_a;
	logic          down_hit;
	logic          up_hit;
	logic          up_room;

	always_comb begin
		cur_ext  = CW'(cur);
		cur_plus = cur_ext + CW'(1);
		up_room  = (cur_plus < CW'(cfg.rate_total)) && (cur_plus < CW'(RATE_SLOTS));

		if (item.first_only) begin
			fail_a = '0;
			succ_a = sat_inc(succ_cnt);
		end else if (cur_ext != CW'(cfg.lowest_index)) begin
			succ_a = '0;
			fail_a = sat_inc(fail_cnt);
		end else begin
			succ_a = cnt_t'(item.acked);
			fail_a = fail_cnt;
		end

		down_hit = !item.first_only && (fail_a == cfg.fail_limit);
		up_hit   = item.first_only && (succ_a == cfg.success_limit);

		fail_nxt = down_hit ? '0 : fail_a;
		succ_nxt = up_hit ? '0 : succ_a;

		flags.down = down_hit && (cur != '0);
		flags.up   = up_hit && up_room;

		preset = (cfg.fail_limit == '0) ? '0 : cnt_t'(cfg.fail_limit - 8'd1);

		if (flags.up) begin
			nxt_rate = IW'(cur_plus);
		end else if (flags.down) begin
			nxt_rate = IW'(cur_ext - CW'(1));
		end else begin
			nxt_rate = cur;
		end

		nxt_ext    = CW'(nxt_rate);
		rate_index = nxt_ext[3:0];
	end

endmodule
